// ===== rtl/latb_pkg.sv =====
// shared types and constants for the load adaptive token bucket
`timescale 1ns / 1ps

package latb_pkg;

    localparam int RATE_W   = 30;
    localparam int LEVEL_W  = 16;
    localparam int TIME_W   = 64;
    localparam int STEP_W   = 7;

    // ns per second, fits in the rate width
    localparam logic [RATE_W-1:0] NS_PER_SEC = 30'd1000000000;

    // values after reset
    localparam logic [RATE_W-1:0]  FULL_RATE_RST     = 30'd10000;
    localparam logic [RATE_W-1:0]  PERIOD_RST        = 30'd100000;
    localparam logic [LEVEL_W-1:0] PAUSE_LEVEL_RST   = 16'd64;
    localparam logic [LEVEL_W-1:0] RESUME_LEVEL_RST  = 16'd16;
    localparam logic [LEVEL_W-1:0] QUARTER_LEVEL_RST = 16'd32;

    // divider step counts
    localparam logic [STEP_W-1:0] STEPS_PERIOD = 7'd30;
    localparam logic [STEP_W-1:0] STEPS_TIME   = 7'd64;

    // configuration register indexes
    localparam logic [1:0] REG_FULL_RATE     = 2'd0;
    localparam logic [1:0] REG_PAUSE_LEVEL   = 2'd1;
    localparam logic [1:0] REG_RESUME_LEVEL  = 2'd2;
    localparam logic [1:0] REG_QUARTER_LEVEL = 2'd3;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== rtl/latb_div.sv =====
// restoring divider, one quotient bit per cycle, 64-bit dividend by 30-bit divisor
`timescale 1ns / 1ps

module latb_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  latb_pkg::t_div_ctl                  i_ctl,
    input  logic [latb_pkg::TIME_W-1:0]         i_dividend,
    input  logic [latb_pkg::RATE_W-1:0]         i_divisor,
    output latb_pkg::t_div_sts                  o_sts,
    output logic [latb_pkg::TIME_W-1:0]         o_quotient
);

    logic [latb_pkg::RATE_W-1:0] r_rem;
    logic [latb_pkg::RATE_W-1:0] r_div;
    logic [latb_pkg::TIME_W-1:0] r_quo;
    logic [latb_pkg::STEP_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [latb_pkg::RATE_W:0]   trial;
    logic [latb_pkg::RATE_W:0]   diff;
    logic                        qbit;

    assign trial = {r_rem, r_quo[latb_pkg::TIME_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign qbit  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[latb_pkg::RATE_W-1:0] : trial[latb_pkg::RATE_W-1:0];
            r_quo <= {r_quo[latb_pkg::TIME_W-2:0], qbit};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/load_adaptive_token_bucket.sv =====
// top level: load adaptive token bucket limiter for background work
`timescale 1ns / 1ps

// usage
// - input channel: i_valid / o_stall carry one poll beat (i_now_time in ns, i_backlog)
// - output channel: o_valid / i_stall carry one result beat (o_granted, o_is_paused)
// - config port: i_cfg_we with i_cfg_addr and i_cfg_data; 0 full rate, 1 pause level,
//   2 resume level, 3 quarter level; write only while no poll is in flight
// - one poll at a time: o_stall is high from acceptance until the result is loaded
// - path from acceptance to o_valid: decide then done for a poll that pauses, stays
//   paused or picks a zero rate; a poll that retunes the rate and refills runs the
//   shared divider twice, 30 steps for the token period and 64 steps for elapsed
//   time / period, then takes a token before done
// - the next poll is taken in the cycle after the result loads
// - a refill without a retune (poll that resumes) needs only the 64-step pass
// - the result sits in an output register; if i_stall holds it, the next poll is
//   still taken and waits at its final step until the register frees
// - reset (synchronous, active low) restores register defaults, clears pause, fills
//   the bucket to the default full rate and forgets the last refill time

module load_adaptive_token_bucket (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // poll channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_now_time,
    input  logic [15:0] i_backlog,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_granted,
    output logic        o_is_paused,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [29:0] i_cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DECIDE  = 7'b0000010,
        ST_DIV_PER = 7'b0000100,
        ST_RUN     = 7'b0001000,
        ST_DIV_ELA = 7'b0010000,
        ST_TAKE    = 7'b0100000,
        ST_DONE    = 7'b1000000
    } t_state;

    // configuration registers
    logic [29:0] r_full_rate;
    logic [15:0] r_pause_lvl;
    logic [15:0] r_resume_lvl;
    logic [15:0] r_quarter_lvl;

    // limiter state
    t_state      r_state,  n_state;
    logic        r_paused, n_paused;
    logic [29:0] r_bucket, n_bucket;
    logic [29:0] r_rate,   n_rate;
    logic [29:0] r_period, n_period;
    logic [63:0] r_last,   n_last;
    logic        r_grant,  n_grant;

    // captured poll
    logic [63:0] r_now;
    logic [15:0] r_backlog;

    // output register
    logic        r_o_valid, n_o_valid;
    logic        r_o_granted;
    logic        r_o_paused;

    // shared divider
    latb_pkg::t_div_ctl div_ctl;
    latb_pkg::t_div_sts div_sts;
    logic [63:0]        div_dividend;
    logic [29:0]        div_divisor;
    logic [63:0]        div_quo;

    logic        in_take;
    logic        out_load;
    logic [29:0] rate_sel;
    logic [30:0] refill_sum;
    logic        fresh_big;

    assign in_take  = i_valid && (r_state == ST_IDLE);
    assign out_load = (r_state == ST_DONE) && (!r_o_valid || !i_stall);

    // tier rate from the current backlog
    always_comb begin
        if (r_backlog >= r_quarter_lvl) begin
            rate_sel = r_full_rate >> 2;
        end else if (r_backlog >= r_resume_lvl) begin
            rate_sel = r_full_rate >> 1;
        end else begin
            rate_sel = r_full_rate;
        end
    end

    // refill arithmetic on the elapsed-time quotient
    assign fresh_big  = (|div_quo[63:30]) || (div_quo[29:0] >= r_rate);
    assign refill_sum = {1'b0, r_bucket} + {1'b0, div_quo[29:0]};

    always_comb begin
        n_state      = r_state;
        n_paused     = r_paused;
        n_bucket     = r_bucket;
        n_rate       = r_rate;
        n_period     = r_period;
        n_last       = r_last;
        n_grant      = r_grant;
        div_ctl      = '{start: 1'b0, steps: latb_pkg::STEPS_TIME};
        div_dividend = r_now - r_last;
        div_divisor  = (r_period == '0) ? 30'd1 : r_period;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_paused) begin
                    if (r_backlog <= r_resume_lvl) begin
                        // resume, keep the current rate
                        n_paused = 1'b0;
                        n_state  = ST_RUN;
                    end else begin
                        n_grant = 1'b0;
                        n_state = ST_DONE;
                    end
                end else if (r_backlog >= r_pause_lvl) begin
                    n_paused = 1'b1;
                    n_grant  = 1'b0;
                    n_state  = ST_DONE;
                end else begin
                    n_rate = rate_sel;
                    if (rate_sel != '0) begin
                        // period = 1e9 / rate, dividend left aligned for 30 steps
                        div_ctl.start = 1'b1;
                        div_ctl.steps = latb_pkg::STEPS_PERIOD;
                        div_dividend  = {latb_pkg::NS_PER_SEC, 34'd0};
                        div_divisor   = rate_sel;
                        n_state       = ST_DIV_PER;
                    end else begin
                        // zero rate grants, bucket untouched
                        n_grant = 1'b1;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DIV_PER: begin
                if (div_sts.done) begin
                    n_period = div_quo[29:0];
                    n_state  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_rate == '0) begin
                    n_grant = 1'b1;
                    n_state = ST_DONE;
                end else if (r_last != '0) begin
                    div_ctl.start = 1'b1;
                    div_ctl.steps = latb_pkg::STEPS_TIME;
                    n_state       = ST_DIV_ELA;
                end else begin
                    n_state = ST_TAKE;
                end
            end
            ST_DIV_ELA: begin
                if (div_sts.done) begin
                    if (fresh_big) begin
                        n_bucket = r_rate;
                    end else if (refill_sum < {1'b0, r_rate}) begin
                        n_bucket = refill_sum[29:0];
                    end else begin
                        n_bucket = r_rate;
                    end
                    n_state = ST_TAKE;
                end
            end
            ST_TAKE: begin
                n_last = r_now;
                if (r_bucket != '0) begin
                    n_bucket = r_bucket - 30'd1;
                    n_grant  = 1'b1;
                end else begin
                    n_grant = 1'b0;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (out_load) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_paused  <= 1'b0;
            r_bucket  <= latb_pkg::FULL_RATE_RST;
            r_rate    <= latb_pkg::FULL_RATE_RST;
            r_period  <= latb_pkg::PERIOD_RST;
            r_last    <= '0;
            r_grant   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_paused  <= n_paused;
            r_bucket  <= n_bucket;
            r_rate    <= n_rate;
            r_period  <= n_period;
            r_last    <= n_last;
            r_grant   <= n_grant;
            r_o_valid <= n_o_valid;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_rate   <= latb_pkg::FULL_RATE_RST;
            r_pause_lvl   <= latb_pkg::PAUSE_LEVEL_RST;
            r_resume_lvl  <= latb_pkg::RESUME_LEVEL_RST;
            r_quarter_lvl <= latb_pkg::QUARTER_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                latb_pkg::REG_FULL_RATE:     r_full_rate   <= i_cfg_data;
                latb_pkg::REG_PAUSE_LEVEL:   r_pause_lvl   <= i_cfg_data[15:0];
                latb_pkg::REG_RESUME_LEVEL:  r_resume_lvl  <= i_cfg_data[15:0];
                latb_pkg::REG_QUARTER_LEVEL: r_quarter_lvl <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // poll capture and result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now     <= i_now_time;
            r_backlog <= i_backlog;
        end
        if (out_load) begin
            r_o_granted <= r_grant;
            r_o_paused  <= r_paused;
        end
    end

    latb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_sts      (div_sts),
        .o_quotient (div_quo)
    );

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_o_valid;
    assign o_granted   = r_o_granted;
    assign o_is_paused = r_o_paused;

    // a paused result never grants
    a_paused_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_paused |-> !r_o_granted)
        else $error("paused result carries a grant");

    // the divider only runs while the sequencer waits on it
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.busy |-> (r_state == ST_DIV_PER) || (r_state == ST_DIV_ELA))
        else $error("divider busy outside a divide state");

    // a divide result always lands in a divide state
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == ST_DIV_PER) || (r_state == ST_DIV_ELA))
        else $error("divider finished with no consumer");

    // the bucket is only drawn from at a nonzero rate
    a_take_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAKE) |-> (r_rate != '0))
        else $error("token taken at zero rate");

endmodule

// ===== dv/latb_checker.sv =====
// scoreboard for the load adaptive token bucket: tracks config writes, predicts and checks each poll
`timescale 1ns / 1ps

module latb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_poll_valid,
    input  logic        i_poll_stall,
    input  logic [63:0] i_now_time,
    input  logic [15:0] i_backlog,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic        i_granted,
    input  logic        i_is_paused,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [29:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_grants
);

    localparam logic [63:0] BILLION = 64'd1_000_000_000;

    typedef struct packed {
        logic granted;
        logic is_paused;
    } t_verdict;

    t_verdict verdict_q[$];

    // register mirror
    logic [29:0] full_rate_r;
    logic [15:0] pause_r;
    logic [15:0] resume_r;
    logic [15:0] quarter_r;

    // limiter state
    logic        paused_s;
    logic [63:0] tokens_s;
    logic [29:0] rate_s;
    logic [63:0] period_s;
    logic [63:0] last_time_s;

    int fail_n;
    int checked_n;
    int grants_n;

    function automatic void reset_state();
        full_rate_r = 30'd10000;
        pause_r     = 16'd64;
        resume_r    = 16'd16;
        quarter_r   = 16'd32;
        paused_s    = 1'b0;
        tokens_s    = 64'd10000;
        rate_s      = 30'd10000;
        period_s    = BILLION / 64'd10000;
        last_time_s = 64'd0;
    endfunction

    function automatic void retune(logic [29:0] rate);
        rate_s = rate;
        if (rate != 30'd0)
            period_s = BILLION / 64'(rate);
    endfunction

    function automatic logic spend_token(logic [63:0] now);
        logic [63:0] elapsed;
        logic [63:0] per;
        logic [63:0] fresh;
        if (rate_s == 30'd0)
            return 1'b1;
        if (last_time_s != 64'd0) begin
            elapsed = now - last_time_s;
            per     = (period_s != 64'd0) ? period_s : 64'd1;
            fresh   = elapsed / per;
            if (fresh >= 64'(rate_s))
                tokens_s = 64'(rate_s);
            else if (tokens_s + fresh < 64'(rate_s))
                tokens_s = tokens_s + fresh;
            else
                tokens_s = 64'(rate_s);
        end
        last_time_s = now;
        if (tokens_s != 64'd0) begin
            tokens_s = tokens_s - 64'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_verdict predict_poll(logic [63:0] now, logic [15:0] load);
        t_verdict v;
        logic     run;
        run = 1'b1;
        if (paused_s) begin
            // resuming keeps the current rate
            if (load <= resume_r)
                paused_s = 1'b0;
            else
                run = 1'b0;
        end else if (load >= pause_r) begin
            paused_s = 1'b1;
            run      = 1'b0;
        end else if (load >= quarter_r) begin
            retune(full_rate_r >> 2);
        end else if (load >= resume_r) begin
            retune(full_rate_r >> 1);
        end else begin
            retune(full_rate_r);
        end
        v.granted   = run ? spend_token(now) : 1'b0;
        v.is_paused = paused_s;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic exp_bit, input logic got_bit);
        fail_n++;
        $display("[%0t] mismatch on %s: expected %0b, got %0b", $realtime, what, exp_bit, got_bit);
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            reset_state();
            verdict_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 1'b0, 1'b1);
                end else begin
                    want = verdict_q.pop_front();
                    checked_n++;
                    if (i_granted === 1'b1)
                        grants_n++;
                    if (i_granted !== want.granted)
                        report_mismatch("granted", want.granted, i_granted);
                    if (i_is_paused !== want.is_paused)
                        report_mismatch("is_paused", want.is_paused, i_is_paused);
                end
            end
            if (i_poll_valid && !i_poll_stall)
                verdict_q.insert(verdict_q.size(), predict_poll(i_now_time, i_backlog));
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    latb_pkg::REG_FULL_RATE:     full_rate_r = i_cfg_data;
                    latb_pkg::REG_PAUSE_LEVEL:   pause_r     = i_cfg_data[15:0];
                    latb_pkg::REG_RESUME_LEVEL:  resume_r    = i_cfg_data[15:0];
                    latb_pkg::REG_QUARTER_LEVEL: quarter_r   = i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_n;
        o_pending    <= verdict_q.size();
        o_checked    <= checked_n;
        o_grants     <= grants_n;
    end

endmodule

// ===== dv/load_adaptive_token_bucket_tb.sv =====
// testbench top for the load adaptive token bucket: poll stimulus, config phases and verdict
`timescale 1ns / 1ps

module load_adaptive_token_bucket_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int POLLS_PER_PHASE = 92;
    localparam int RANDOM_PHASES = 10;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [63:0] i_now_time  = 64'd0;
    logic [15:0] i_backlog   = 16'd0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic        o_granted;
    logic        o_is_paused;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_addr  = latb_pkg::REG_FULL_RATE;
    logic [29:0] i_cfg_data  = 30'd0;

    int fail_count;
    int pending;
    int checked;
    int grants;

    // idle percentages for each side, changed per phase
    int send_idle_pct = 14;
    int recv_idle_pct = 77;

    // stimulus-side copy of the limits, only used to aim the random beats
    logic [29:0] cur_full_rate = 30'd10000;
    logic [15:0] cur_pause     = 16'd64;
    logic [15:0] cur_resume    = 16'd16;
    logic [15:0] cur_quarter   = 16'd32;
    logic [63:0] tick_ns       = 64'd100000;
    logic [63:0] cur_time      = 64'd0;
    int          walk_backlog  = 16;
    int          n_settings    = 1;
    int          quiet_cycles  = 0;

    logic poll_beat;
    logic result_beat;
    assign poll_beat   = i_valid && !o_stall;
    assign result_beat = o_valid && !i_stall;

    load_adaptive_token_bucket dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_now_time  (i_now_time),
        .i_backlog   (i_backlog),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_granted   (o_granted),
        .o_is_paused (o_is_paused),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    latb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_poll_valid (i_valid),
        .i_poll_stall (o_stall),
        .i_now_time   (i_now_time),
        .i_backlog    (i_backlog),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_granted    (o_granted),
        .i_is_paused  (o_is_paused),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_grants     (grants)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // reset held low from the start, then released and never asserted again
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // result side back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // no beat of any kind for too long means the block hung
    always @(posedge i_clk) begin
        if (!i_rst_n || poll_beat || result_beat || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one poll beat, with random idle cycles ahead of it, and hold it until taken
    task automatic send_poll(input logic [63:0] stamp, input logic [15:0] load);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_now_time <= stamp;
        i_backlog  <= load;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
    endtask

    // drop valid and wait until every outstanding result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [29:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // writes all four limits while the block is idle; level writes carry junk upper bits
    task automatic program_limits(input logic [29:0] rate, input logic [15:0] pause_lvl,
                                  input logic [15:0] resume_lvl, input logic [15:0] quarter_lvl);
        logic [13:0] junk;
        wait_drained();
        junk = 14'($urandom);
        write_reg(latb_pkg::REG_FULL_RATE, rate);
        write_reg(latb_pkg::REG_PAUSE_LEVEL, {junk, pause_lvl});
        write_reg(latb_pkg::REG_RESUME_LEVEL, {~junk, resume_lvl});
        write_reg(latb_pkg::REG_QUARTER_LEVEL, {junk ^ 14'h2AAA, quarter_lvl});
        i_cfg_we      <= 1'b0;
        cur_full_rate = rate;
        cur_pause     = pause_lvl;
        cur_resume    = resume_lvl;
        cur_quarter   = quarter_lvl;
        tick_ns       = 64'd1_000_000_000 / ((rate == 30'd0) ? 64'd1 : 64'(rate));
        n_settings++;
    endtask

    function automatic logic [15:0] near_level(input logic [15:0] lvl);
        int v;
        v = int'(lvl) + int'($urandom_range(0, 2)) - 1;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // often a slow walk so pause and resume happen in natural order, plus aimed hits, extremes and random draws
    function automatic logic [15:0] next_backlog();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                walk_backlog = walk_backlog + int'($urandom_range(0, 8)) - 4;
                if (walk_backlog < 0)
                    walk_backlog = 0;
                if (walk_backlog > 65535)
                    walk_backlog = 65535;
                return walk_backlog[15:0];
            end
            4:       return near_level(cur_pause);
            5:       return near_level(cur_resume);
            6:       return near_level(cur_quarter);
            7:       return 16'd0;
            8:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // time mostly advances by a few token periods; sometimes zero, backwards or wild
    function automatic logic [63:0] next_time();
        case ($urandom_range(0, 24))
            0:       return 64'd0;
            1:       cur_time = cur_time - 64'($urandom_range(1, 100000));
            2:       cur_time = {$urandom, $urandom};
            3:       cur_time = cur_time + {$urandom, $urandom};
            default: cur_time = cur_time + (tick_ns * 64'($urandom_range(0, 12))) / 64'd4
                                + 64'($urandom_range(0, 999));
        endcase
        return cur_time;
    endfunction

    initial begin
        int          ph;
        int          n;
        logic [29:0] rate;
        logic [15:0] r_lvl;
        logic [15:0] q_lvl;
        logic [15:0] p_lvl;

        cur_time = {$urandom, $urandom};
        @(posedge i_rst_n);
        @(posedge i_clk);

        // directed beats at the reset limits: zero stamp, tiers, wrap, pause hysteresis
        send_poll(64'd0, 16'd0);
        send_poll(64'd1000, 16'd16);               // half tier, bucket left above rate
        send_poll(64'hFFFF_FFFF_FFFF_FFFF, 16'd32); // quarter tier, huge elapsed
        send_poll(64'd5, 16'd63);                  // elapsed wraps around
        send_poll(64'd6, 16'd64);                  // pause
        send_poll(64'd7, 16'hFFFF);                // stays paused
        send_poll(64'd8, 16'd17);                  // just above resume, still paused
        send_poll(64'd9, 16'd16);                  // resume at the threshold, no retune

        // tiny rate so the bucket runs dry; quarter of 2 is a zero rate
        program_limits(30'd2, 16'd10, 16'd3, 16'd6);
        send_poll(64'd1_000_000_000, 16'd0);
        send_poll(64'd1_000_000_000, 16'd0);
        send_poll(64'd1_000_000_000, 16'd0);       // bucket empty, denied
        send_poll(64'd1_500_000_000, 16'd0);
        send_poll(64'd2_500_000_000, 16'd3);
        send_poll(64'd2_500_000_000, 16'd6);       // zero rate grants
        send_poll(64'd2_500_000_000, 16'd10);
        send_poll(64'd2_500_000_000, 16'd4);
        send_poll(64'd2_500_000_000, 16'd3);       // resume keeps the zero rate

        // widest rate: period rounds to zero at full, tiny at half
        program_limits(30'h3FFF_FFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        send_poll(64'hAAAA_5555_AAAA_5555, 16'd0);
        send_poll(64'hAAAA_5555_AAAA_5558, 16'hFFFE);
        send_poll(64'hAAAA_5555_AAAA_5559, 16'hFFFF);
        send_poll(64'hAAAA_5555_AAAA_555A, 16'd0);

        program_limits(30'd1_000_000_000, 16'd64, 16'd16, 16'd32);
        send_poll(64'd1, 16'd0);
        program_limits(30'd0, 16'd64, 16'd16, 16'd32);
        send_poll(64'd123, 16'd0);

        // random phases, each with its own limits
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 14;
                recv_idle_pct = 77;
            end else if (ph < 6) begin
                send_idle_pct = 77;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            r_lvl = 16'($urandom_range(0, 20));
            q_lvl = r_lvl + 16'($urandom_range(0, 12));
            p_lvl = q_lvl + 16'($urandom_range(1, 12));
            case (ph % 5)
                0: rate = 30'($urandom_range(1, 12));
                1: rate = 30'd0;
                2: begin
                    rate  = 30'h3FFF_FFFF;
                    p_lvl = 16'hFFFF;
                    r_lvl = 16'd0;
                end
                3: rate = ($urandom_range(0, 3) == 0) ? 30'd1_000_000_000
                                                       : 30'($urandom_range(13, 60));
                default: begin
                    // unordered limits anywhere in range
                    rate  = 30'($urandom_range(1, 30));
                    p_lvl = 16'($urandom);
                    r_lvl = 16'($urandom);
                    q_lvl = 16'($urandom);
                end
            endcase
            program_limits(rate, p_lvl, r_lvl, q_lvl);
            walk_backlog = int'(r_lvl);

            for (n = 0; n < POLLS_PER_PHASE; n++)
                send_poll(next_time(), next_backlog());
        end

        wait_drained();
        // let any stray result show up before the verdict
        repeat (150) @(posedge i_clk);

        $display("checked %0d poll results (%0d granted) over %0d limit settings",
                 checked, grants, n_settings);
        $display("run hit all rate tiers, pause and resume, zero rate, zero and wrapping stamps");
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
